[src/nine_slice_coordinate_mapper_assert.svh]
// Assertion macros for the nine-slice coordinate mapper.
`ifndef NINE_SLICE_COORDINATE_MAPPER_ASSERT_SVH
`define NINE_SLICE_COORDINATE_MAPPER_ASSERT_SVH
`ifndef SYNTH
`define NSCM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define NSCM_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define NSCM_ASSERT_ALWAYS(lbl, cond, msg)
`define NSCM_ASSERT_IMPLY(lbl, pre, post, msg)
`endif
`endif

[src/nscm_pkg.sv]
// Package of the nine-slice coordinate mapper: widths, types and the axis set-up function.
package nscm_pkg;

  localparam int CoordIntBits  = 12;
  localparam int CoordFracBits = 4;
  localparam int CoordBits     = CoordIntBits + CoordFracBits;
  localparam int RegW          = 12;
  localparam int CfgIdxW       = 3;
  localparam int OffW          = RegW + CoordFracBits;
  localparam int VW            = (CoordBits > OffW) ? CoordBits : OffW;
  localparam int NspW          = RegW + 1;
  localparam int NendW         = RegW + 2;
  localparam int PW            = OffW + NspW;
  localparam int QW            = CoordFracBits + RegW + 1;
  localparam int EndW          = NendW + CoordFracBits;
  localparam int RW            = ((EndW > CoordBits) ? EndW : CoordBits) + 1;

  localparam logic [CoordBits-1:0] CoordMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegStretchLeft   = 3'd0,
    RegStretchTop    = 3'd1,
    RegStretchRight  = 3'd2,
    RegStretchBottom = 3'd3,
    RegSourceWidth   = 3'd4,
    RegSourceHeight  = 3'd5,
    RegTargetWidth   = 3'd6,
    RegTargetHeight  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RegionPass = 2'd0,
    RegionMid  = 2'd1,
    RegionEnd  = 2'd2
  } region_e;

  typedef struct packed {
    logic [CoordBits-1:0] source_x;
    logic [CoordBits-1:0] source_y;
  } in_t;

  typedef struct packed {
    logic [CoordBits-1:0] mapped_x;
    logic [CoordBits-1:0] mapped_y;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    logic [RegW-1:0] lo;
    logic [RegW-1:0] hi;
    logic [RegW-1:0] src;
    logic [RegW-1:0] tgt;
  } axis_cfg_t;

  typedef struct packed {
    logic [OffW-1:0]  lq;
    logic [OffW-1:0]  rq;
    logic [RegW-1:0]  span;
    logic [NspW-1:0]  new_span;
    logic [NendW-1:0] new_end;
  } axis_drv_t;

  typedef struct packed {
    region_e         region;
    logic [VW-1:0]   val;
    logic [RegW-1:0] rem;
    logic [QW-1:0]   acc;
  } lane_t;

  function automatic axis_drv_t axis_derive(axis_cfg_t c);
    logic signed [RegW+2:0] diff;
    axis_drv_t d;
    diff = $signed({3'b000, c.tgt}) + $signed({3'b000, c.hi})
         - $signed({3'b000, c.lo}) - $signed({3'b000, c.src});
    d.new_span = diff[RegW+2] ? '0 : diff[NspW-1:0];
    d.new_end  = {2'b00, c.lo} + {1'b0, d.new_span};
    d.span     = c.hi - c.lo;
    d.lq       = OffW'(c.lo) << CoordFracBits;
    d.rq       = OffW'(c.hi) << CoordFracBits;
    return d;
  endfunction

endpackage

[src/nine_slice_coordinate_mapper.sv]
// Top level of the nine-slice coordinate mapper.
//
// Input channel: in_valid_i / in_stall_o carry a source (x, y) pair in
// unsigned Q12.4; a beat is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry the mapped pair and a flag
// that is set when either axis clamped to the field maximum.
// Configuration: cfg_we_i writes cfg_data_i into the register cfg_idx_i;
// write only while no beat is in flight.
// The pipeline has two front stages (region decode, span multiply), one
// cell per quotient bit of the stretch division (17 cells) and one output
// register. Throughput is one beat per cycle while the output is not stalled;
// the divider cell chain sets the depth.
// Reset clears every stage and loads the register reset values.
// A stalled output holds its beat; each stage holds while the next is full,
// so empty stages keep filling and input is taken until the chain is full.
module nine_slice_coordinate_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nscm_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nscm_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [nscm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nscm_pkg::RegW-1:0]      cfg_data_i
);
  import nscm_pkg::*;

  axis_cfg_t [1:0]          cfg_q;
  axis_drv_t [1:0]          drv;
  logic [1:0][RegW-1:0]     span;
  logic                     front_ready;
  logic [QW:0]              chain_valid, chain_ready;
  lane_t [QW:0][1:0]        chain_lane;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        cfg_q[k].lo  <= '0;
        cfg_q[k].hi  <= '0;
        cfg_q[k].src <= RegW'(1);
        cfg_q[k].tgt <= RegW'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStretchLeft:   cfg_q[0].lo  <= cfg_data_i;
        RegStretchTop:    cfg_q[1].lo  <= cfg_data_i;
        RegStretchRight:  cfg_q[0].hi  <= cfg_data_i;
        RegStretchBottom: cfg_q[1].hi  <= cfg_data_i;
        RegSourceWidth:   cfg_q[0].src <= cfg_data_i;
        RegSourceHeight:  cfg_q[1].src <= cfg_data_i;
        RegTargetWidth:   cfg_q[0].tgt <= cfg_data_i;
        RegTargetHeight:  cfg_q[1].tgt <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      drv[k]  = axis_derive(cfg_q[k]);
      span[k] = drv[k].span;
    end
  end

  assign in_stall_o = !front_ready;

  nscm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (front_ready),
    .data_i  (in_data_i),
    .drv_i   (drv),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .lane_o  (chain_lane[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    nscm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .lane_i  (chain_lane[i]),
      .div_i   (span),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .lane_o  (chain_lane[i+1])
    );
  end

  nscm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[QW]),
    .ready_o (chain_ready[QW]),
    .lane_i  (chain_lane[QW]),
    .drv_i   (drv),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

`include "nine_slice_coordinate_mapper_assert.svh"

  `NSCM_ASSERT_ALWAYS(a_stall_only_when_blocked, !in_stall_o || (out_valid_o && out_stall_i), "input stalled while the output drains")
  `NSCM_ASSERT_IMPLY(a_sat_clamps, out_valid_o && out_data_o.saturated, (out_data_o.mapped_x == CoordMax || out_data_o.mapped_y == CoordMax), "saturated without a clamped coordinate")

endmodule

[src/nscm_front.sv]
// Front end of the mapper: region decode, offset and span multiply, two stages.
module nscm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  nscm_pkg::in_t                data_i,
  input  nscm_pkg::axis_drv_t [1:0]    drv_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output nscm_pkg::lane_t [1:0]        lane_o
);
  import nscm_pkg::*;

  logic                      p_valid_q;
  region_e  [1:0]            p_region_q, p_region_d;
  logic     [1:0][VW-1:0]    p_val_q, p_val_d;
  logic                      m_valid_q;
  lane_t    [1:0]            m_lane_q, m_lane_d;
  logic                      p_ready, m_ready;
  logic     [1:0][CoordBits-1:0] coord;

  assign coord   = {data_i.source_y, data_i.source_x};
  assign m_ready = !m_valid_q || ready_i;
  assign p_ready = !p_valid_q || m_ready;
  assign ready_o = p_ready;
  assign valid_o = m_valid_q;
  assign lane_o  = m_lane_q;

  always_comb begin
    logic [VW-1:0] c, lq, rq;
    logic [PW-1:0] prod;
    for (int k = 0; k < 2; k++) begin
      c  = VW'(coord[k]);
      lq = VW'(drv_i[k].lq);
      rq = VW'(drv_i[k].rq);
      if (c <= lq) begin
        p_region_d[k] = RegionPass;
        p_val_d[k]    = c;
      end else if (c >= rq) begin
        p_region_d[k] = RegionEnd;
        p_val_d[k]    = c - rq;
      end else begin
        p_region_d[k] = RegionMid;
        p_val_d[k]    = c - lq;
      end
      prod = PW'(p_val_q[k][OffW-1:0]) * PW'(drv_i[k].new_span);
      m_lane_d[k].region = p_region_q[k];
      m_lane_d[k].val    = p_val_q[k];
      m_lane_d[k].rem    = prod[PW-1:QW];
      m_lane_d[k].acc    = prod[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (p_ready) p_valid_q <= valid_i;
      if (m_ready) m_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && valid_i) begin
      p_region_q <= p_region_d;
      p_val_q    <= p_val_d;
    end
    if (m_ready && p_valid_q) begin
      m_lane_q <= m_lane_d;
    end
  end

endmodule

[src/nscm_cell.sv]
// One restoring division step for both axes, one pipeline stage.
module nscm_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  nscm_pkg::lane_t [1:0]             lane_i,
  input  logic [1:0][nscm_pkg::RegW-1:0]    div_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output nscm_pkg::lane_t [1:0]             lane_o
);
  import nscm_pkg::*;

  logic          valid_q;
  lane_t [1:0]   lane_q, lane_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign lane_o  = lane_q;

  always_comb begin
    logic [RegW:0] t;
    logic          qbit;
    for (int k = 0; k < 2; k++) begin
      t    = {lane_i[k].rem, lane_i[k].acc[QW-1]};
      qbit = (t >= {1'b0, div_i[k]});
      lane_d[k].region = lane_i[k].region;
      lane_d[k].val    = lane_i[k].val;
      lane_d[k].rem    = qbit ? RegW'(t - {1'b0, div_i[k]}) : t[RegW-1:0];
      lane_d[k].acc    = {lane_i[k].acc[QW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) lane_q <= lane_d;
  end

endmodule

[src/nscm_back.sv]
// Back end of the mapper: final position, clamp and output register.
module nscm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  nscm_pkg::lane_t [1:0]      lane_i,
  input  nscm_pkg::axis_drv_t [1:0]  drv_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output nscm_pkg::out_t             data_o
);
  import nscm_pkg::*;

  logic                       valid_q;
  out_t                       data_q, data_d;
  logic [1:0][CoordBits-1:0]  mapped;
  logic [1:0]                 sat;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic [RW-1:0] r;
    for (int k = 0; k < 2; k++) begin
      case (lane_i[k].region)
        RegionMid: r = RW'(lane_i[k].acc) + RW'(drv_i[k].lq);
        RegionEnd: r = (RW'(drv_i[k].new_end) << CoordFracBits) + RW'(lane_i[k].val);
        default:   r = RW'(lane_i[k].val);
      endcase
      sat[k]    = |r[RW-1:CoordBits];
      mapped[k] = sat[k] ? CoordMax : r[CoordBits-1:0];
    end
    data_d.mapped_x  = mapped[0];
    data_d.mapped_y  = mapped[1];
    data_d.saturated = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

[bench/tb.sv]
// Self-checking testbench for the nine-slice coordinate mapper.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nscm_pkg::*;

  localparam int CycleLimit   = 1_000_000;
  localparam int DrainCycles  = 25;
  localparam int RandomPhases = 8;
  localparam int BeatsPerSet  = 220;
  localparam int FracOne      = 1 << CoordFracBits;
  localparam longint CoordTop = (longint'(1) << CoordBits) - 1;

  class mapped_coord_book;
    axis_cfg_t x_axis;
    axis_cfg_t y_axis;
    out_t      pending_maps[$];
    int        fails;

    function new();
      x_axis = '{lo: '0, hi: '0, src: RegW'(1), tgt: RegW'(1)};
      y_axis = x_axis;
      fails  = 0;
    endfunction

    function void load(cfg_reg_e idx, logic [RegW-1:0] v);
      case (idx)
        RegStretchLeft:   x_axis.lo  = v;
        RegStretchTop:    y_axis.lo  = v;
        RegStretchRight:  x_axis.hi  = v;
        RegStretchBottom: y_axis.hi  = v;
        RegSourceWidth:   x_axis.src = v;
        RegSourceHeight:  y_axis.src = v;
        RegTargetWidth:   x_axis.tgt = v;
        RegTargetHeight:  y_axis.tgt = v;
        default: ;
      endcase
    endfunction

    // {clamped, position}
    function logic [CoordBits:0] map_axis(logic [CoordBits-1:0] coord, axis_cfg_t ax);
      longint c, lo_px, hi_px, src_px, tgt_px, floor_px, eff_px, new_hi, lq, rq, r;
      c        = longint'(coord);
      lo_px    = longint'(ax.lo);
      hi_px    = longint'(ax.hi);
      src_px   = longint'(ax.src);
      tgt_px   = longint'(ax.tgt);
      floor_px = lo_px + (src_px - hi_px);
      eff_px   = (tgt_px < floor_px) ? floor_px : tgt_px;
      new_hi   = eff_px - (src_px - hi_px);
      lq       = lo_px * FracOne;
      rq       = hi_px * FracOne;
      if (c <= lq) begin
        r = c;
      end else if (c >= rq) begin
        r = new_hi * FracOne + (c - rq);
      end else begin
        r = (c - lq) * (new_hi - lo_px) / (hi_px - lo_px) + lq;
      end
      if (r < 0) r = 0;
      if (r > CoordTop) return {1'b1, CoordMax};
      return {1'b0, CoordBits'(r)};
    endfunction

    function void note_source(in_t s);
      logic [CoordBits:0] mx, my;
      out_t e;
      mx          = map_axis(s.source_x, x_axis);
      my          = map_axis(s.source_y, y_axis);
      e.mapped_x  = mx[CoordBits-1:0];
      e.mapped_y  = my[CoordBits-1:0];
      e.saturated = mx[CoordBits] | my[CoordBits];
      pending_maps.push_back(e);
    endfunction

    function void check_mapped(out_t got);
      out_t e;
      if (pending_maps.size() == 0) begin
        $error("mapped beat with nothing pending: x %0d y %0d sat %0b",
               got.mapped_x, got.mapped_y, got.saturated);
        fails++;
        return;
      end
      e = pending_maps.pop_front();
      if (got.mapped_x !== e.mapped_x) begin
        $error("mapped_x: expected %0d, actual %0d", e.mapped_x, got.mapped_x);
        fails++;
      end
      if (got.mapped_y !== e.mapped_y) begin
        $error("mapped_y: expected %0d, actual %0d", e.mapped_y, got.mapped_y);
        fails++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated: expected %0b, actual %0b", e.saturated, got.saturated);
        fails++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [RegW-1:0]     cfg_data_i;

  mapped_coord_book book = new();
  int cycles     = 0;
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;

  nine_slice_coordinate_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) book.check_mapped(out_data_o);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = pick_gap() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [CoordBits-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > CoordTop) return CoordMax;
    return CoordBits'(v);
  endfunction

  function automatic logic [CoordBits-1:0] pick_coord(axis_cfg_t ax);
    int lq, rq, roll;
    lq   = int'(ax.lo) * FracOne;
    rq   = int'(ax.hi) * FracOne;
    roll = $urandom_range(9);
    if (roll < 4) return CoordBits'($urandom);
    if (roll < 7 && lq < rq) return CoordBits'($urandom_range(lq, rq));
    case ($urandom_range(5))
      0: return clip(lq - 1);
      1: return clip(lq);
      2: return clip(lq + 1);
      3: return clip(rq - 1);
      4: return clip(rq);
      default: return clip(rq + 1);
    endcase
  endfunction

  function automatic axis_cfg_t random_axis();
    axis_cfg_t ax;
    int src_px;
    if ($urandom_range(9) < 7) begin
      src_px = $urandom_range(1, 4095);
      ax.src = RegW'(src_px);
      ax.hi  = RegW'($urandom_range(0, src_px));
      ax.lo  = RegW'($urandom_range(0, ax.hi));
      if ($urandom_range(3) == 0) begin
        ax.tgt = RegW'($urandom);
      end else begin
        ax.tgt = RegW'($urandom_range(0, (2 * src_px > 4095) ? 4095 : 2 * src_px));
      end
    end else begin
      ax = axis_cfg_t'($urandom_range(0, 16777215) * 64'd16777216 +
                       $urandom_range(0, 16777215));
    end
    return ax;
  endfunction

  task automatic load_axes(axis_cfg_t ax, axis_cfg_t ay);
    logic [RegW-1:0] vals [8];
    vals[RegStretchLeft]   = ax.lo;
    vals[RegStretchTop]    = ay.lo;
    vals[RegStretchRight]  = ax.hi;
    vals[RegStretchBottom] = ay.hi;
    vals[RegSourceWidth]   = ax.src;
    vals[RegSourceHeight]  = ay.src;
    vals[RegTargetWidth]   = ax.tgt;
    vals[RegTargetHeight]  = ay.tgt;
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      book.load(cfg_reg_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_source(logic [CoordBits-1:0] sx, logic [CoordBits-1:0] sy);
    in_t s;
    s.source_x = sx;
    s.source_y = sy;
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    book.note_source(s);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending_maps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // just inside the lower stretch corner, just short of the upper corner, on it, then the field extremes
  task automatic send_corners();
    send_source(clip(int'(book.x_axis.lo) * FracOne + 1),
                clip(int'(book.y_axis.lo) * FracOne + 1));
    send_source(clip(int'(book.x_axis.hi) * FracOne - 1),
                clip(int'(book.y_axis.hi) * FracOne - 1));
    send_source(clip(int'(book.x_axis.hi) * FracOne),
                clip(int'(book.y_axis.hi) * FracOne));
    send_source(CoordMax, '0);
  endtask

  initial begin
    axis_cfg_t ax, ay;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 20;
    stall_pct = 20;
    send_corners();
    drain();

    // target equal to the border minimum on y
    ax = '{lo: 12'd10, hi: 12'd20, src: 12'd32, tgt: 12'd100};
    ay = '{lo: 12'd4, hi: 12'd12, src: 12'd16, tgt: 12'd8};
    load_axes(ax, ay);
    send_source('0, '0);
    send_source(CoordMax, CoordMax);
    send_source('0, CoordMax);
    send_source(16'h5555, 16'haaaa);
    send_source(16'haaaa, 16'h5555);
    send_source(clip(int'(ax.lo) * FracOne), clip(int'(ay.lo) * FracOne));
    send_source(16'd250, 16'd100);
    send_source(16'd320, 16'd192);
    send_source(16'd170, 16'd70);
    drain();

    // widest registers: stretch spans the whole y range
    load_axes('{lo: '1, hi: '1, src: '1, tgt: '1}, '{lo: '0, hi: '1, src: '1, tgt: '1});
    send_corners();
    drain();

    // end before start on x, source smaller than the end on y
    load_axes('{lo: 12'd100, hi: 12'd50, src: 12'd200, tgt: 12'd3000},
              '{lo: 12'd10, hi: 12'd300, src: 12'd100, tgt: 12'd4095});
    send_corners();
    drain();

    load_axes('0, '0);
    send_corners();
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 3) * 20;
        stall_pct = $urandom_range(0, 3) * 20;
      end
      load_axes(random_axis(), random_axis());
      for (int n = 0; n < BeatsPerSet; n++) begin
        send_source(pick_coord(book.x_axis), pick_coord(book.y_axis));
      end
      drain();
    end

    if (book.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/nscm_pkg.sv
src/nscm_front.sv
src/nscm_cell.sv
src/nscm_back.sv
src/nine_slice_coordinate_mapper.sv
bench/tb.sv
